@@ design/fpr_pkg.sv @@
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants for the frame pixel streamer
// Request and format codes, register indexes, config and queue entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

  // request codes
  localparam logic [1:0] REQ_PAL_WRITE   = 2'd0;
  localparam logic [1:0] REQ_FRAME_START = 2'd1;
  localparam logic [1:0] REQ_PIXEL       = 2'd2;
  localparam logic [1:0] REQ_FRAME_END   = 2'd3;

  // pixel formats
  localparam logic [1:0] FMT_INDEXED = 2'd0;
  localparam logic [1:0] FMT_RGB555  = 2'd1;
  localparam logic [1:0] FMT_RGB565  = 2'd2;
  localparam logic [1:0] FMT_XRGB    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_PIXEL_FORMAT    = 3'd2;
  localparam logic [2:0] REG_FRAME_SKIP      = 3'd3;
  localparam logic [2:0] REG_DUMMY_MODE      = 3'd4;
  localparam logic [2:0] REG_START_SIGNATURE = 3'd5;
  localparam logic [2:0] REG_ABORT_SIGNATURE = 3'd6;

  localparam logic [31:0] STOP_BYTE = 32'h0000_0001;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [1:0]  pixel_format;
    logic [7:0]  frame_skip;
    logic        dummy_mode;
    logic [31:0] start_signature;
    logic [31:0] abort_signature;
  } fpr_cfg_t;

  // one queued job: up to three results, all bytes or all words
  typedef struct packed {
    logic [1:0]  cnt;
    logic        is_word;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [7:0]  b2;
  } fpr_entry_t;

endpackage

`default_nettype wire

@@ design/fpr_front.sv @@
// ----------------------------------------------------------------------------
// fpr_front: request decode, frame state and palette
// Accepts items, updates frame state, expands pixels and queues result jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_front #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire                   clk,
  input  wire                   rst,
  input  fpr_pkg::fpr_cfg_t     cfg,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire [1:0]             req_type,
  input  wire [31:0]            pixel_value,
  input  wire [7:0]             pal_index,
  input  wire [7:0]             pal_red,
  input  wire [7:0]             pal_green,
  input  wire [7:0]             pal_blue,
  input  wire                   sink_busy,
  input  wire                   abort_frame,
  output logic                  q_push,
  output fpr_pkg::fpr_entry_t   q_data,
  input  wire                   q_full
);
  import fpr_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0]                pal_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_valid;
  logic [23:0]                pal_rd;
  logic                       pal_rd_ok;

  logic       started;
  logic       drawing;
  logic [7:0] skip_count;

  logic       s1_valid;
  logic       s1_pal;
  fpr_entry_t s1_ent;

  logic       accept;
  logic       push;
  logic       use_pal;
  fpr_entry_t ent;
  logic       wr_in_range;
  logic       rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [23:0] pal_px;
  logic       skip_short;

  assign in_ready    = !s1_valid || !q_full;
  assign accept      = in_valid && in_ready;
  assign wr_in_range = {1'b0, pal_index} < 9'(PALETTE_ENTRIES);
  assign rd_in_range = {1'b0, pixel_value[7:0]} < 9'(PALETTE_ENTRIES);
  assign wr_addr     = pal_index[AW-1:0];
  assign rd_addr     = pixel_value[AW-1:0];
  assign skip_short  = skip_count < cfg.frame_skip;

  // classify the item and build its result job
  always_comb begin
    ent     = '0;
    push    = 1'b0;
    use_pal = 1'b0;
    case (req_type)
      REQ_FRAME_START: begin
        if (started && !cfg.dummy_mode) begin
          push        = 1'b1;
          ent.cnt     = 2'd2;
          ent.is_word = 1'b1;
          ent.w0      = cfg.start_signature;
          ent.w1      = {cfg.frame_width, cfg.frame_height};
        end
      end
      REQ_PIXEL: begin
        if (drawing && !cfg.dummy_mode) begin
          push    = 1'b1;
          ent.cnt = 2'd3;
          case (cfg.pixel_format)
            FMT_INDEXED: use_pal = 1'b1;
            FMT_RGB555: begin
              ent.w0 = {24'd0, pixel_value[4:0], pixel_value[4:2]};
              ent.w1 = {24'd0, pixel_value[9:5], pixel_value[9:7]};
              ent.b2 = {pixel_value[14:10], pixel_value[14:12]};
            end
            FMT_RGB565: begin
              ent.w0 = {24'd0, pixel_value[4:0], pixel_value[4:2]};
              ent.w1 = {24'd0, pixel_value[10:5], pixel_value[10:9]};
              ent.b2 = {pixel_value[15:11], pixel_value[15:13]};
            end
            default: begin
              ent.w0 = {24'd0, pixel_value[7:0]};
              ent.w1 = {24'd0, pixel_value[15:8]};
              ent.b2 = pixel_value[23:16];
            end
          endcase
        end
      end
      REQ_FRAME_END: begin
        if (!cfg.dummy_mode) begin
          push    = 1'b1;
          ent.cnt = 2'd1;
          if (abort_frame || skip_short) begin
            ent.is_word = 1'b1;
            ent.w0      = cfg.abort_signature;
          end else begin
            ent.w0 = STOP_BYTE;
          end
        end
      end
      default: ;
    endcase
  end

  // palette storage, read data registered at accept
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_PAL_WRITE && wr_in_range) begin
      pal_mem[wr_addr] <= {pal_red, pal_green, pal_blue};
    end
    if (accept) begin
      pal_rd <= pal_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
      pal_rd_ok <= 1'b0;
    end else if (accept) begin
      pal_rd_ok <= pal_valid[rd_addr] && rd_in_range;
      if (req_type == REQ_PAL_WRITE && wr_in_range) begin
        pal_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      drawing    <= 1'b0;
      skip_count <= '0;
    end else if (accept) begin
      case (req_type)
        REQ_FRAME_START: begin
          if (!started) begin
            started    <= 1'b1;
            skip_count <= '0;
            drawing    <= 1'b0;
          end else if (cfg.dummy_mode) begin
            drawing <= 1'b0;
          end else begin
            drawing <= !skip_short && !sink_busy;
          end
        end
        REQ_FRAME_END: begin
          skip_count <= skip_short ? skip_count + 8'd1 : 8'd0;
          drawing    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // hold stage: waits for queue room, picks up the palette read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && push;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_ent <= ent;
      s1_pal <= use_pal;
    end
  end

  assign pal_px = pal_rd_ok ? pal_rd : 24'd0;
  assign q_push = s1_valid && !q_full;

  always_comb begin
    q_data = s1_ent;
    if (s1_pal) begin
      q_data.w0 = {24'd0, pal_px[7:0]};
      q_data.w1 = {24'd0, pal_px[15:8]};
      q_data.b2 = pal_px[23:16];
    end
  end

endmodule

`default_nettype wire

@@ design/fpr_queue.sv @@
// ----------------------------------------------------------------------------
// fpr_queue: job queue between front and back
// Small FIFO of result jobs so decode and output stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  fpr_pkg::fpr_entry_t   push_data,
  output logic                  full,
  input  wire                   pop,
  output logic                  q_valid,
  output fpr_pkg::fpr_entry_t   q_data
);
  import fpr_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fpr_entry_t    slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full    = count == CW'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (pop)  rptr <= rptr + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/fpr_back.sv @@
// ----------------------------------------------------------------------------
// fpr_back: result sequencer
// Pops a queued job, sends its results one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   q_valid,
  output logic                  q_pop,
  input  fpr_pkg::fpr_entry_t   q_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [31:0]           out_data,
  output logic                  out_is_word,
  output logic                  last
);
  import fpr_pkg::*;

  fpr_entry_t cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       sent;
  logic       load;

  assign out_valid   = cur_valid;
  assign out_is_word = cur.is_word;
  assign last        = idx == cur.cnt - 2'd1;
  assign sent        = cur_valid && out_ready;
  assign load        = !cur_valid || (sent && last);
  assign q_pop       = load && q_valid;

  always_comb begin
    case (idx)
      2'd0:    out_data = cur.w0;
      2'd1:    out_data = cur.w1;
      default: out_data = {24'd0, cur.b2};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= q_valid;
      idx       <= '0;
    end else if (sent) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

endmodule

`default_nettype wire

@@ design/frame_pixel_to_rgb888_streamer.sv @@
// ----------------------------------------------------------------------------
// frame_pixel_to_rgb888_streamer: display request to byte/word stream
// Palette, frame skip and pixel expansion to blue, green, red bytes.
//
//   channel  signals                           direction
//   in       in_valid/in_ready + request       sink of items
//   out      out_valid/out_ready + result      source of results
//   cfg      cfg_we, cfg_index, cfg_data       register writes
//
// A pixel gives three results at the output, one per byte; the back
// sequencer sends one result per cycle while out_ready is high and sets
// the sustained rate. An accepted item passes the hold stage, the job queue
// and the back sequencer's current-job register before out_valid rises.
// Reset clears state and the palette valid bits directly; no sweep.
// A stalled output fills the two-entry job queue and the hold stage,
// then stops input.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pixel_to_rgb888_streamer #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire [2:0]   cfg_index,
  input  wire [31:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [1:0]   req_type,
  input  wire [31:0]  pixel_value,
  input  wire [7:0]   pal_index,
  input  wire [7:0]   pal_red,
  input  wire [7:0]   pal_green,
  input  wire [7:0]   pal_blue,
  input  wire         sink_busy,
  input  wire         abort_frame,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_data,
  output logic        out_is_word,
  output logic        last
);
  import fpr_pkg::*;

  fpr_cfg_t   cfg;
  fpr_entry_t push_data;
  fpr_entry_t q_data;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[15:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[15:0];
        REG_PIXEL_FORMAT:    cfg.pixel_format    <= cfg_data[1:0];
        REG_FRAME_SKIP:      cfg.frame_skip      <= cfg_data[7:0];
        REG_DUMMY_MODE:      cfg.dummy_mode      <= cfg_data[0];
        REG_START_SIGNATURE: cfg.start_signature <= cfg_data;
        REG_ABORT_SIGNATURE: cfg.abort_signature <= cfg_data;
        default: ;
      endcase
    end
  end

  fpr_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .pixel_value (pixel_value),
    .pal_index   (pal_index),
    .pal_red     (pal_red),
    .pal_green   (pal_green),
    .pal_blue    (pal_blue),
    .sink_busy   (sink_busy),
    .abort_frame (abort_frame),
    .q_push      (q_push),
    .q_data      (push_data),
    .q_full      (q_full)
  );

  fpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  fpr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .out_is_word (out_is_word),
    .last        (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_push |-> push_data.cnt != 2'd0)
    else $error("empty job queued");

  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

`default_nettype wire
